>>> rtl/core/tbht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbht_pkg: shared types and constants of the two-way bucket hash table
// Request, response, slot and bucket layouts, request codes and FSM states.
// ----------------------------------------------------------------------------
package tbht_pkg;

	localparam int KEY_W   = 64;
	localparam int DATA_W  = 64;
	localparam int COUNT_W = 32;

	localparam int AGE_LSB   = 40;
	localparam int DEPTH_LSB = 48;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_STORE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [1:0] SLOT_NONE = 2'd0;
	localparam logic [1:0] SLOT_ONE  = 2'd1;
	localparam logic [1:0] SLOT_TWO  = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic [1:0]        req_type;
		logic [KEY_W-1:0]  search_key;
		logic [DATA_W-1:0] entry_data;
		logic [7:0]        new_depth;
		logic [7:0]        search_age;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [DATA_W-1:0]  found_data;
		logic [1:0]         store_slot;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  mixed;
		logic [DATA_W-1:0] data;
	} slot_t;

	typedef struct packed {
		slot_t s1;
		slot_t s2;
	} bucket_t;

	typedef struct packed {
		logic               wr_en;
		bucket_t            wr_data;
		logic [COUNT_W-1:0] count;
		rsp_t               rsp;
	} dec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_LOOK,
		ST_SWEEP
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/tbht_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbht_mem: bucket memory
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module tbht_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  tbht_pkg::bucket_t      wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output tbht_pkg::bucket_t      rd_data
);
	import tbht_pkg::*;

	bucket_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/tbht_index.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbht_index: bucket index from the search key
// Power-of-two depth takes the low key bits at once; any other depth runs
// a four-bit-per-cycle remainder over all sixteen nibbles of the key.
// ----------------------------------------------------------------------------
module tbht_index #(
	parameter int BUCKETS = 1024,
	parameter int IDX_W   = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [tbht_pkg::KEY_W-1:0] key,
	output logic                            done,
	output logic [IDX_W-1:0]                idx
);
	import tbht_pkg::*;

	if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
		assign done = start;
		assign idx  = key[IDX_W-1:0];
	end else begin : g_serial
		logic [KEY_W-1:0] key_sh_q;
		logic [IDX_W-1:0] r_q;
		logic [IDX_W-1:0] r_d;
		logic [3:0]       cnt_q;
		logic             busy_q;
		logic             done_q;
		logic [IDX_W+3:0] t;
		logic [IDX_W+3:0] sub;

		// t stays below 16 * BUCKETS, so four compare-subtract steps reduce it
		always_comb begin
			t = {r_q, key_sh_q[KEY_W-1 -: 4]};
			sub = '0;
			for (int k = 3; k >= 0; k--) begin
				sub = (IDX_W+4)'(BUCKETS) << k;
				if (t >= sub) begin
					t = t - sub;
				end
			end
			r_d = t[IDX_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				done_q <= 1'b0;
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				key_sh_q <= key;
				r_q      <= '0;
			end else if (busy_q) begin
				key_sh_q <= {key_sh_q[KEY_W-5:0], 4'b0};
				r_q      <= r_d;
			end
		end

		assign done = done_q;
		assign idx  = r_q;
	end

endmodule
`default_nettype wire

>>> rtl/core/tbht_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbht_decide: lookup and replacement decision for one bucket
// Matches both slots, scores them by age and depth, builds the write-back
// bucket, the next entry count and the response.
// ----------------------------------------------------------------------------
module tbht_decide (
	input  tbht_pkg::req_t                    req,
	input  tbht_pkg::bucket_t                 bucket,
	input  wire logic [tbht_pkg::COUNT_W-1:0] count,
	output tbht_pkg::dec_t                    dec
);
	import tbht_pkg::*;

	logic               match1;
	logic               match2;
	logic [7:0]         age1;
	logic [7:0]         age2;
	logic [7:0]         dep1;
	logic [7:0]         dep2;
	logic signed [8:0]  da1;
	logic signed [8:0]  da2;
	logic signed [8:0]  dd1;
	logic signed [8:0]  dd2;
	logic signed [16:0] sc1;
	logic signed [16:0] sc2;
	logic [COUNT_W-1:0] bumped;
	slot_t              fresh;

	assign match1 = bucket.s1.valid
		&& ((bucket.s1.mixed ^ bucket.s1.data) == req.search_key);
	assign match2 = bucket.s2.valid
		&& ((bucket.s2.mixed ^ bucket.s2.data) == req.search_key);

	assign age1 = bucket.s1.data[AGE_LSB +: 8];
	assign age2 = bucket.s2.data[AGE_LSB +: 8];
	assign dep1 = bucket.s1.data[DEPTH_LSB +: 8];
	assign dep2 = bucket.s2.data[DEPTH_LSB +: 8];

	assign da1 = $signed({1'b0, req.search_age}) - $signed({1'b0, age1});
	assign da2 = $signed({1'b0, req.search_age}) - $signed({1'b0, age2});
	assign dd1 = $signed({1'b0, req.new_depth}) - $signed({1'b0, dep1});
	assign dd2 = $signed({1'b0, req.new_depth}) - $signed({1'b0, dep2});

	// age difference weighted by 128
	assign sc1 = $signed({da1[8], da1, 7'b0}) + $signed({{8{dd1[8]}}, dd1});
	assign sc2 = $signed({da2[8], da2, 7'b0}) + $signed({{8{dd2[8]}}, dd2});

	assign bumped = (count != COUNT_MAX) ? count + COUNT_W'(1) : count;

	assign fresh = '{valid: 1'b1,
		mixed: req.search_key ^ req.entry_data,
		data: req.entry_data};

	always_comb begin
		dec = '0;
		dec.wr_data = bucket;
		dec.count = count;
		unique case (req.req_type)
			REQ_LOOKUP: begin
				if (match1) begin
					dec.rsp.hit = 1'b1;
					dec.rsp.found_data = bucket.s1.data;
				end else if (match2) begin
					dec.rsp.hit = 1'b1;
					dec.rsp.found_data = bucket.s2.data;
				end
			end
			REQ_STORE: begin
				priority if (!bucket.s1.valid) begin
					dec.wr_en = 1'b1;
					dec.wr_data.s1 = fresh;
					dec.count = bumped;
					dec.rsp.store_slot = SLOT_ONE;
				end else if (!bucket.s2.valid) begin
					dec.wr_en = 1'b1;
					dec.wr_data.s2 = fresh;
					dec.count = bumped;
					dec.rsp.store_slot = SLOT_TWO;
				end else if (match1 || (!match2 && !(sc1 < 0 && sc2 < 0) && sc1 >= sc2))
					begin
					dec.wr_en = 1'b1;
					dec.wr_data.s1 = fresh;
					dec.count = (age1 != req.search_age) ? bumped : count;
					dec.rsp.store_slot = SLOT_ONE;
				end else if (match2 || !(sc1 < 0 && sc2 < 0)) begin
					dec.wr_en = 1'b1;
					dec.wr_data.s2 = fresh;
					dec.count = (age2 != req.search_age) ? bumped : count;
					dec.rsp.store_slot = SLOT_TWO;
				end else begin
					dec.wr_en = 1'b0;
				end
			end
			REQ_CLEAR: begin
				dec.count = '0;
			end
			default: begin
				dec.wr_en = 1'b0;
			end
		endcase
		dec.rsp.entry_count = dec.count;
	end

endmodule
`default_nettype wire

>>> rtl/core/two_way_bucket_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_way_bucket_hash_table: hash table of two-slot buckets
// Lookup, store with age/depth replacement, and whole-table clear.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one request; rsp channel (valid/ready)
//   returns exactly one response per request, in order.
//   Each lookup or store reads its bucket from a one-port-read, one-port-write
//   memory and decides on the read data; a store may write the bucket back.
//   With BUCKETS a power of two the index is the low key bits and the bucket
//   is read in the transfer cycle. Any other BUCKETS derives the index by a
//   4-bit-per-cycle remainder before the read. Either way a new request is
//   taken only after the previous response has been registered.
//   Valid bits live in the bucket memory. After reset and after each clear
//   a sweep writes every bucket empty, one bucket per cycle; req_ready stays
//   low meanwhile. A clear response is issued before its sweep starts.
//   rsp is an output register: when the receiver stalls the response holds,
//   and a following request waits in its decision cycle until the register
//   frees.
// ----------------------------------------------------------------------------
module two_way_bucket_hash_table #(
	parameter int BUCKETS = 1024
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  tbht_pkg::req_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output tbht_pkg::rsp_t rsp
);
	import tbht_pkg::*;

	localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	state_t             state_q;
	state_t             state_d;
	req_t               req_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   sweep_q;
	logic [COUNT_W-1:0] count_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic               accept;
	logic               idx_start;
	logic               idx_done;
	logic [IDX_W-1:0]   idx_val;
	logic               rd_en;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	bucket_t            wr_data;
	bucket_t            rd_data;
	logic               out_free;
	logic               commit;
	logic               sweep_last;
	dec_t               dec;

	assign accept     = req_valid && req_ready;
	assign idx_start  = accept && (req.req_type != REQ_CLEAR);
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign sweep_last = (sweep_q == IDX_W'(BUCKETS - 1));

	tbht_index #(
		.BUCKETS (BUCKETS),
		.IDX_W   (IDX_W)
	) u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (idx_start),
		.key    (req.search_key),
		.done   (idx_done),
		.idx    (idx_val)
	);

	tbht_mem #(
		.DEPTH  (BUCKETS),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_val),
		.rd_data (rd_data)
	);

	tbht_decide u_decide (
		.req    (req_q),
		.bucket (rd_data),
		.count  (count_q),
		.dec    (dec)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_CLEAR || idx_done) begin
						state_d = ST_LOOK;
					end else begin
						state_d = ST_HASH;
					end
				end
			end
			ST_HASH: begin
				if (idx_done) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					state_d = (req_q.req_type == REQ_CLEAR) ? ST_SWEEP : ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		commit    = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = dec.wr_data;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				rd_en     = idx_start && idx_done;
			end
			ST_HASH: begin
				rd_en = idx_done;
			end
			ST_LOOK: begin
				commit = out_free;
				wr_en  = out_free && dec.wr_en;
			end
			ST_SWEEP: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = '0;
			end
			default: req_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_last ? '0 : sweep_q + IDX_W'(1);
			end
			if (commit) begin
				count_q     <= dec.count;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rd_en) begin
			idx_q <= idx_val;
		end
		if (commit) begin
			rsp_q <= dec.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

>>> rtl/core/tbht_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbht_checker: port-level checks of the hash table
// Response hold under stall, busy after a transfer, response field coherence.
// ----------------------------------------------------------------------------
module tbht_checker (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_ready,
	input tbht_pkg::req_t req,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input tbht_pkg::rsp_t rsp
);
	import tbht_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in flight");

	a_hit_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> rsp.store_slot == SLOT_NONE)
		else $error("hit together with store outcome");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.found_data == '0)
		else $error("nonzero data without hit");

	a_req_type_seen: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == REQ_CLEAR
			|=> !rsp_valid || rsp.entry_count == '0 || $past(rsp_valid && !rsp_ready))
		else $error("clear response with nonzero count");

endmodule

bind two_way_bucket_hash_table tbht_checker u_tbht_checker (.*);
`default_nettype wire
